[rtl/hps_pkg.sv]
`timescale 1ns / 1ps

package hps_pkg;

	localparam int HW = 16;
	localparam int COL_W = 10;
	localparam int ROW_W = 16;

	// line buffer depth, matches the 10-bit column field
	localparam int MAX_WIDTH = 1024;

	// request codes
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_DRAIN  = 1'b1;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_X = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_Y = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_LIGHT_POS_Z = 3'd4;

	// queue between front and back
	localparam int QDEPTH = 4;
	localparam int QAW    = 2;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
		logic [HW-1:0]    p;
		logic [HW-1:0]    left;
		logic [HW-1:0]    right;
		logic [HW-1:0]    top;
		logic [HW-1:0]    bottom;
	} pix_t;

	typedef struct packed {
		logic valid;
		pix_t pix;
	} push_t;

	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} tag_t;

endpackage

[rtl/hps_if.sv]
`timescale 1ns / 1ps

interface hps_in_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [15:0] height_sample;

	modport source (output valid, output req_type, output height_sample, input ready);
	modport sink (input valid, input req_type, input height_sample, output ready);
endinterface

interface hps_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] intensity;
	logic [9:0]  out_col;
	logic [15:0] out_row;
	logic        frame_last;

	modport source (output valid, output intensity, output out_col, output out_row,
		output frame_last, input ready);
	modport sink (input valid, input intensity, input out_col, input out_row,
		input frame_last, output ready);
endinterface

[rtl/hps_front.sv]
`timescale 1ns / 1ps

module hps_front import hps_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	hps_in_if.sink        pix_in,
	input  logic [10:0]   map_width,
	input  logic [15:0]   map_rows,
	input  logic          q_full,
	output push_t         push
);

	localparam int CAW = $clog2(MAX_WIDTH);
	localparam int WB  = $clog2(MAX_WIDTH + 1);
	localparam int EW  = (WB > 11) ? WB : 11;
	localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);

	logic [HW-1:0] center_mem [0:MAX_WIDTH-1];
	logic [HW-1:0] upper_mem  [0:MAX_WIDTH-1];

	logic [CAW-1:0] col_q, drn_q;
	logic [15:0]    row_q;
	logic [HW-1:0]  rd_p_q, rd_right_q, rd_top_q, left_q;

	logic [EW-1:0]  mw, weff, c_inc;
	logic [15:0]    rows_eff;
	logic [CAW-1:0] c, col_n, drn_n, addr_n, addr_n1;
	logic [15:0]    row_n;
	logic           accept, is_drain, frame_full, act_samp, act_drain, last_col;
	logic [HW-1:0]  p, h, left, right;

	assign mw       = EW'(map_width);
	assign weff     = (mw == '0) ? EW'(1) : ((mw > MAXW) ? MAXW : mw);
	assign rows_eff = (map_rows == 16'd0) ? 16'd1 : map_rows;

	// one of the two counters is always zero
	assign c        = col_q | drn_q;
	assign c_inc    = EW'(c) + EW'(1);
	assign last_col = (c_inc >= weff);

	assign pix_in.ready = !q_full;
	assign accept     = pix_in.valid && pix_in.ready;
	assign is_drain   = (pix_in.req_type == REQ_DRAIN);
	assign frame_full = (row_q >= rows_eff);
	assign act_samp   = accept && !is_drain && !frame_full;
	assign act_drain  = accept && is_drain && frame_full;

	assign p     = rd_p_q;
	assign h     = pix_in.height_sample;
	assign left  = (c != '0) ? left_q : p;
	assign right = last_col ? p : rd_right_q;

	always_comb begin
		push.valid     = act_drain || (act_samp && (row_q != 16'd0));
		push.pix.col   = COL_W'(c);
		push.pix.p     = p;
		push.pix.left  = left;
		push.pix.right = right;
		if (is_drain) begin
			push.pix.row    = rows_eff - 16'd1;
			push.pix.last   = last_col;
			push.pix.top    = (rows_eff > 16'd1) ? rd_top_q : p;
			push.pix.bottom = p;
		end else begin
			push.pix.row    = row_q - 16'd1;
			push.pix.last   = 1'b0;
			push.pix.top    = (row_q >= 16'd2) ? rd_top_q : p;
			push.pix.bottom = h;
		end
	end

	always_comb begin
		col_n = col_q;
		drn_n = drn_q;
		row_n = row_q;
		if (act_samp) begin
			if (last_col) begin
				col_n = '0;
				row_n = row_q + 16'd1;
			end else begin
				col_n = col_q + CAW'(1);
			end
		end else if (act_drain) begin
			if (last_col) begin
				col_n = '0;
				drn_n = '0;
				row_n = '0;
			end else begin
				drn_n = drn_q + CAW'(1);
			end
		end
	end

	assign addr_n  = col_n | drn_n;
	assign addr_n1 = addr_n + CAW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			drn_q <= '0;
			row_q <= '0;
		end else begin
			col_q <= col_n;
			drn_q <= drn_n;
			row_q <= row_n;
		end
	end

	// line buffers, read ahead for the next column with write-first bypass
	always_ff @(posedge clk) begin
		if (act_samp)
			center_mem[c] <= h;
		if (act_samp || act_drain)
			upper_mem[c] <= p;
		rd_p_q     <= (act_samp && c == addr_n) ? h : center_mem[addr_n];
		rd_right_q <= (act_samp && c == addr_n1) ? h : center_mem[addr_n1];
		rd_top_q   <= ((act_samp || act_drain) && c == addr_n) ? p : upper_mem[addr_n];
		if (act_samp || act_drain)
			left_q <= p;
	end

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(push.valid && push.pix.last) |=> (row_q == 16'd0 && col_q == '0 && drn_q == '0))
		else $error("frame end did not clear counters");

	a_one_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q == '0) || (drn_q == '0))
		else $error("column and drain counters both active");

endmodule

[rtl/hps_fifo.sv]
`timescale 1ns / 1ps

module hps_fifo import hps_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t push,
	input  logic  pop,
	output logic  full,
	output logic  empty,
	output pix_t  dout
);

	pix_t           buf_q [0:QDEPTH-1];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0]   cnt_q;

	assign full  = (cnt_q == (QAW+1)'(QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = buf_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push.valid)
				wr_q <= wr_q + QAW'(1);
			if (pop)
				rd_q <= rd_q + QAW'(1);
			if (push.valid && !pop)
				cnt_q <= cnt_q + (QAW+1)'(1);
			else if (!push.valid && pop)
				cnt_q <= cnt_q - (QAW+1)'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid)
			buf_q[wr_q] <= push.pix;
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push.valid && full))
		else $error("queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && empty))
		else $error("queue underflow");

endmodule

[rtl/hps_back.sv]
`timescale 1ns / 1ps

module hps_back import hps_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] light_pos_x,
	input  logic signed [15:0] light_pos_y,
	input  logic [15:0]        light_pos_z,
	input  logic               q_empty,
	input  pix_t               q_data,
	output logic               pop,
	hps_out_if.source          pix_out
);

	localparam int SQ_N = 32;
	localparam int DV_N = 17;

	function automatic logic [25:0] mag26(input logic [25:0] v);
		return v[25] ? (~v + 26'd1) : v;
	endfunction

	function automatic logic [4:0] shift_of(input logic [25:0] m);
		logic [4:0] s;
		s = 5'd0;
		for (int i = 15; i < 26; i++)
			if (m[i])
				s = 5'(i - 14);
		return s;
	endfunction

	function automatic logic [15:0] rescale(input logic [25:0] v, input logic [4:0] s);
		logic [25:0] t;
		t = mag26(v) >> s;
		return v[25] ? (~t[15:0] + 16'd1) : t[15:0];
	endfunction

	logic adv;
	logic out_v_q;

	// stage 1: raw vectors
	logic               v_s1, zero_s1;
	tag_t               tag_s1;
	logic signed [16:0] n0_s1, n1_s1, l2_s1;
	logic signed [25:0] l0_s1, l1_s1;
	logic signed [17:0] dx, dy;
	logic signed [16:0] l2c;

	assign pop = adv && !q_empty;
	assign dx  = $signed({8'b0, q_data.col}) - $signed({{2{light_pos_x[15]}}, light_pos_x});
	assign dy  = $signed({2'b0, q_data.row}) - $signed({{2{light_pos_y[15]}}, light_pos_y});
	assign l2c = $signed({1'b0, q_data.p}) - $signed({1'b0, light_pos_z});

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s1  <= '{col: q_data.col, row: q_data.row, last: q_data.last};
			zero_s1 <= (dx == '0) && (dy == '0) && (l2c == '0);
			n0_s1   <= $signed({1'b0, q_data.left}) - $signed({1'b0, q_data.right});
			n1_s1   <= $signed({1'b0, q_data.top}) - $signed({1'b0, q_data.bottom});
			l0_s1   <= {dx, 8'b0};
			l1_s1   <= {dy, 8'b0};
			l2_s1   <= l2c;
		end
	end

	// stage 2: block scaling
	logic               v_s2, zero_s2;
	tag_t               tag_s2;
	logic signed [15:0] ls0_s2, ls1_s2, ls2_s2, ns0_s2, ns1_s2, ns2_s2;
	logic [4:0]         sh_l, sh_n;

	assign sh_l = shift_of(mag26(l0_s1) | mag26(l1_s1) | mag26(26'(l2_s1)));
	assign sh_n = shift_of(mag26(26'(n0_s1)) | mag26(26'(n1_s1)) | 26'd512);

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s2  <= tag_s1;
			zero_s2 <= zero_s1;
			ls0_s2  <= rescale(l0_s1, sh_l);
			ls1_s2  <= rescale(l1_s1, sh_l);
			ls2_s2  <= rescale(26'(l2_s1), sh_l);
			ns0_s2  <= rescale(26'(n0_s1), sh_n);
			ns1_s2  <= rescale(26'(n1_s1), sh_n);
			ns2_s2  <= rescale(26'd512, sh_n);
		end
	end

	// stage 3: products
	logic               v_s3, zero_s3;
	tag_t               tag_s3;
	logic signed [31:0] ln0_s3, ln1_s3, ln2_s3, ll0_s3, ll1_s3, ll2_s3, nn0_s3, nn1_s3, nn2_s3;

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s3  <= tag_s2;
			zero_s3 <= zero_s2;
			ln0_s3  <= ls0_s2 * ns0_s2;
			ln1_s3  <= ls1_s2 * ns1_s2;
			ln2_s3  <= ls2_s2 * ns2_s2;
			ll0_s3  <= ls0_s2 * ls0_s2;
			ll1_s3  <= ls1_s2 * ls1_s2;
			ll2_s3  <= ls2_s2 * ls2_s2;
			nn0_s3  <= ns0_s2 * ns0_s2;
			nn1_s3  <= ns1_s2 * ns1_s2;
			nn2_s3  <= ns2_s2 * ns2_s2;
		end
	end

	// stage 4: sums
	logic               v_s4, zero_s4;
	tag_t               tag_s4;
	logic [32:0]        d_s4;
	logic [31:0]        lsq_s4, nsq_s4;
	logic signed [33:0] dneg;

	assign dneg = 34'(ln0_s3) + 34'(ln1_s3) + 34'(ln2_s3);

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_s4  <= tag_s3;
			zero_s4 <= zero_s3 || (dneg >= 34'sd0);
			d_s4    <= 33'(-dneg);
			lsq_s4  <= $unsigned(ll0_s3) + $unsigned(ll1_s3) + $unsigned(ll2_s3);
			nsq_s4  <= $unsigned(nn0_s3) + $unsigned(nn1_s3) + $unsigned(nn2_s3);
		end
	end

	// stage 5 feeds the square root chain at index 0
	logic [63:0] sq_x_s   [0:SQ_N];
	logic [63:0] sq_r_s   [0:SQ_N];
	logic [32:0] sq_d_s   [0:SQ_N];
	tag_t        sq_tag_s [0:SQ_N];
	logic        sq_z_s   [0:SQ_N];
	logic        sq_v_s   [0:SQ_N];

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x_s[0]   <= 64'(lsq_s4) * 64'(nsq_s4);
			sq_r_s[0]   <= '0;
			sq_d_s[0]   <= d_s4;
			sq_tag_s[0] <= tag_s4;
			sq_z_s[0]   <= zero_s4;
		end
	end

	for (genvar k = 0; k < SQ_N; k++) begin : g_sqrt
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
		logic [63:0] t;
		assign t = sq_r_s[k] + BIT;

		always_ff @(posedge clk) begin
			if (adv) begin
				if (sq_x_s[k] >= t) begin
					sq_x_s[k+1] <= sq_x_s[k] - t;
					sq_r_s[k+1] <= (sq_r_s[k] >> 1) + BIT;
				end else begin
					sq_x_s[k+1] <= sq_x_s[k];
					sq_r_s[k+1] <= sq_r_s[k] >> 1;
				end
				sq_d_s[k+1]   <= sq_d_s[k];
				sq_tag_s[k+1] <= sq_tag_s[k];
				sq_z_s[k+1]   <= sq_z_s[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				sq_v_s[k+1] <= 1'b0;
			else if (adv)
				sq_v_s[k+1] <= sq_v_s[k];
		end
	end

	// restoring division, one quotient bit per stage
	logic [32:0] dv_rem_s [1:DV_N];
	logic [31:0] dv_s_s   [1:DV_N];
	logic [16:0] dv_q_s   [1:DV_N];
	tag_t        dv_tag_s [1:DV_N];
	logic        dv_z_s   [1:DV_N];
	logic        dv_v_s   [1:DV_N];

	for (genvar k = 0; k < DV_N; k++) begin : g_div
		logic [33:0] rin;
		logic [31:0] sv;
		logic [16:0] qin;
		tag_t        tin;
		logic        zin, vin, ge;

		if (k == 0) begin : g_first
			assign rin = 34'(sq_d_s[SQ_N]);
			assign sv  = sq_r_s[SQ_N][31:0];
			assign qin = '0;
			assign tin = sq_tag_s[SQ_N];
			assign zin = sq_z_s[SQ_N] || (sq_r_s[SQ_N] == '0);
			assign vin = sq_v_s[SQ_N];
		end else begin : g_next
			assign rin = {dv_rem_s[k], 1'b0};
			assign sv  = dv_s_s[k];
			assign qin = dv_q_s[k];
			assign tin = dv_tag_s[k];
			assign zin = dv_z_s[k];
			assign vin = dv_v_s[k];
		end

		assign ge = (rin >= 34'(sv));

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_rem_s[k+1] <= ge ? 33'(rin - 34'(sv)) : rin[32:0];
				dv_s_s[k+1]   <= sv;
				dv_q_s[k+1]   <= {qin[15:0], ge};
				dv_tag_s[k+1] <= tin;
				dv_z_s[k+1]   <= zin;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				dv_v_s[k+1] <= 1'b0;
			else if (adv)
				dv_v_s[k+1] <= vin;
		end
	end

	// output register
	logic [15:0] int_q;
	tag_t        tag_q;

	assign adv = !out_v_q || pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			sq_v_s[0] <= 1'b0;
			out_v_q   <= 1'b0;
		end else if (adv) begin
			v_s1      <= !q_empty;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			sq_v_s[0] <= v_s4;
			out_v_q   <= dv_v_s[DV_N];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tag_q <= dv_tag_s[DV_N];
			if (dv_z_s[DV_N])
				int_q <= '0;
			else if (dv_q_s[DV_N][16])
				int_q <= 16'hFFFF;
			else
				int_q <= dv_q_s[DV_N][15:0];
		end
	end

	assign pix_out.valid      = out_v_q;
	assign pix_out.intensity  = int_q;
	assign pix_out.out_col    = tag_q.col;
	assign pix_out.out_row    = tag_q.row;
	assign pix_out.frame_last = tag_q.last;

	a_pop_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> v_s1)
		else $error("popped request lost at stage one");

	a_stall_freezes: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> ($stable(v_s1) && $stable(sq_v_s[0])))
		else $error("pipeline moved while stalled");

endmodule

[rtl/heightmap_point_light_shading_core.sv]
`timescale 1ns / 1ps

// channel   dir  handshake          payload
// pix_in    in   valid/ready        req_type, height_sample
// pix_out   out  valid/ready        intensity, out_col, out_row, frame_last
// cfg       in   cfg_we (no ready)  cfg_index, cfg_wdata
//
// one request per cycle sustained, in and out, while pix_out is ready and
// the queue is not full; each sample is shaded one row later, after a front
// stage (line buffers) and a back pipeline: queue entry, five arithmetic
// stages, 32 square root stages, 17 divide stages and the output register.
// reset clears counters and valids; line buffers hold whatever was there
// until written. a stalled output freezes the back pipeline, the four-entry
// queue then fills and only then is pix_in held off.

module heightmap_point_light_shading_core import hps_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	hps_in_if.sink                pix_in,
	hps_out_if.source             pix_out,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// configuration registers
	logic [10:0]        map_width_q;
	logic [15:0]        map_rows_q;
	logic signed [15:0] light_x_q, light_y_q;
	logic [15:0]        light_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q <= 11'd256;
			map_rows_q  <= 16'd256;
			light_x_q   <= '0;
			light_y_q   <= '0;
			light_z_q   <= 16'hFFFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MAP_WIDTH:   map_width_q <= cfg_wdata[10:0];
				CFG_MAP_ROWS:    map_rows_q  <= cfg_wdata;
				CFG_LIGHT_POS_X: light_x_q   <= cfg_wdata;
				CFG_LIGHT_POS_Y: light_y_q   <= cfg_wdata;
				CFG_LIGHT_POS_Z: light_z_q   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// front: counters, line buffers, neighbour gathering
	push_t push;
	logic  q_full, q_empty, q_pop;
	pix_t  q_data;

	hps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_in    (pix_in),
		.map_width (map_width_q),
		.map_rows  (map_rows_q),
		.q_full    (q_full),
		.push      (push)
	);

	// short queue decoupling the front from the shading pipeline
	hps_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.dout   (q_data)
	);

	// back: vector build, normalisation and intensity
	hps_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.light_pos_x (light_x_q),
		.light_pos_y (light_y_q),
		.light_pos_z (light_z_q),
		.q_empty     (q_empty),
		.q_data      (q_data),
		.pop         (q_pop),
		.pix_out     (pix_out)
	);

endmodule
